/* sv/acpu_pkg.sv */
// Shared types and constants for the accumulator CPU core.
// Holds request, opcode, status and sequencer codes plus default depths.
// No dependencies.
package acpu_pkg;

  localparam int DATA_DEPTH_DEF = 128;
  localparam int PROG_DEPTH_DEF = 128;
  localparam int WORD_W = 32;
  localparam int PC_W = 7;
  localparam int LADDR_W = 7;

  typedef enum logic [2:0] {
    REQ_EXEC    = 3'd0,
    REQ_PRELOAD = 3'd1,
    REQ_SET_PC  = 3'd2,
    REQ_SET_ACC = 3'd3,
    REQ_RESUME  = 3'd4
  } req_t;

  typedef enum logic [3:0] {
    OP_LDI  = 4'd0,
    OP_LD   = 4'd1,
    OP_LDX  = 4'd2,
    OP_ST   = 4'd3,
    OP_STX  = 4'd4,
    OP_ADD  = 4'd5,
    OP_NEG  = 4'd6,
    OP_BRZ  = 4'd7,
    OP_HALT = 4'd8,
    OP_RD   = 4'd9,
    OP_WR   = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    STAT_NORMAL  = 3'd0,
    STAT_ILLEGAL = 3'd1,
    STAT_MEMVIOL = 3'd2,
    STAT_READ    = 3'd3,
    STAT_WRITE   = 3'd4,
    STAT_STOP    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_IND
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [PC_W-1:0]   pc;
    status_t           status;
  } arch_t;

  typedef struct packed {
    logic mem_we;
    logic ind_read;
  } exec_ctl_t;

endpackage

/* sv/acpu_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package needed.
module acpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/acpu_exec.sv */
// Instruction and request evaluation for the accumulator CPU core.
// Computes the next architectural state and the data memory write for one item.
// Depends on acpu_pkg.
module acpu_exec
  import acpu_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  parameter int PROG_DEPTH = PROG_DEPTH_DEF,
  localparam int AW = $clog2(DATA_DEPTH)
) (
  input  arch_t                     cur,
  input  logic [AW-1:0]             top,
  input  logic [2:0]                req_type,
  input  logic [3:0]                opcode,
  input  logic signed [WORD_W-1:0]  operand,
  input  logic [LADDR_W-1:0]        load_address,
  input  logic signed [WORD_W-1:0]  load_value,
  input  logic [WORD_W-1:0]         rdata,
  output arch_t                     nxt,
  output logic [AW-1:0]             top_next,
  output exec_ctl_t                 ctl,
  output logic [AW-1:0]             waddr,
  output logic [WORD_W-1:0]         wdata
);

  logic                  n_ok;
  logic                  p_ok;
  logic                  pc_ok;
  logic                  br_ok;
  logic                  la_ok;
  logic [AW-1:0]         n_addr;
  logic [AW-1:0]         p_addr;
  logic [AW+LADDR_W-1:0] la_ext;
  logic [AW-1:0]         la_addr;
  logic [PC_W-1:0]       pc_inc;

  assign n_ok    = $unsigned(operand) < 32'(DATA_DEPTH);
  assign p_ok    = rdata < 32'(DATA_DEPTH);
  assign pc_ok   = {{(32-PC_W){1'b0}}, cur.pc} < 32'(PROG_DEPTH);
  assign br_ok   = $unsigned(operand) < 32'(PROG_DEPTH);
  assign la_ok   = {{(32-LADDR_W){1'b0}}, load_address} < 32'(DATA_DEPTH);
  assign n_addr  = operand[AW-1:0];
  assign p_addr  = rdata[AW-1:0];
  assign la_ext  = {{AW{1'b0}}, load_address};
  assign la_addr = la_ext[AW-1:0];
  assign pc_inc  = cur.pc + PC_W'(1);

  always_comb begin
    nxt      = cur;
    top_next = top;
    ctl      = '0;
    waddr    = n_addr;
    wdata    = cur.acc;
    case (req_type)
      REQ_EXEC: begin
        if (cur.status == STAT_NORMAL) begin
          if (!pc_ok) begin
            nxt.status = STAT_MEMVIOL;
          end else begin
            case (opcode)
              OP_LDI: begin
                nxt.acc = operand;
                nxt.pc  = pc_inc;
              end
              OP_LD, OP_ADD: begin
                if (!n_ok) begin
                  nxt.status = STAT_MEMVIOL;
                end else begin
                  nxt.acc = (opcode == OP_LD) ? rdata : cur.acc + rdata;
                  nxt.pc  = pc_inc;
                end
              end
              OP_LDX: begin
                if (!n_ok || !p_ok) begin
                  nxt.status = STAT_MEMVIOL;
                end else begin
                  ctl.ind_read = 1'b1;
                end
              end
              OP_STX: begin
                if (!n_ok || !p_ok) begin
                  nxt.status = STAT_MEMVIOL;
                end else begin
                  ctl.mem_we = 1'b1;
                  waddr      = p_addr;
                  top_next   = (p_addr > top) ? p_addr : top;
                  nxt.pc     = pc_inc;
                end
              end
              OP_ST: begin
                if (!n_ok) begin
                  nxt.status = STAT_MEMVIOL;
                end else begin
                  ctl.mem_we = 1'b1;
                  top_next   = (n_addr > top) ? n_addr : top;
                  nxt.pc     = pc_inc;
                end
              end
              OP_NEG: begin
                nxt.acc = 32'd0 - cur.acc;
                nxt.pc  = pc_inc;
              end
              OP_BRZ: begin
                if (cur.acc == 32'd0) begin
                  if (!br_ok) begin
                    nxt.status = STAT_MEMVIOL;
                  end else begin
                    nxt.pc = operand[PC_W-1:0];
                  end
                end else begin
                  nxt.pc = pc_inc;
                end
              end
              OP_HALT: begin
                nxt.status = STAT_STOP;
                nxt.pc     = pc_inc;
              end
              OP_RD: begin
                nxt.status = STAT_READ;
                nxt.pc     = pc_inc;
              end
              OP_WR: begin
                nxt.status = STAT_WRITE;
                nxt.pc     = pc_inc;
              end
              default: begin
                nxt.status = STAT_ILLEGAL;
              end
            endcase
          end
        end
      end
      REQ_PRELOAD: begin
        if (la_ok) begin
          ctl.mem_we = 1'b1;
          waddr      = la_addr;
          wdata      = load_value;
        end
      end
      REQ_SET_PC: begin
        nxt.pc = load_address;
      end
      REQ_SET_ACC: begin
        nxt.acc = load_value;
      end
      REQ_RESUME: begin
        nxt.status = STAT_NORMAL;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/accumulator_cpu_core.sv */
// Top level of the accumulator CPU core: sequencer, state registers, data memory.
// Depends on acpu_pkg, acpu_exec and acpu_ram.
//
// Each input transfer is one request: execute an instruction, preload a data
// word, set the PC, set the accumulator or resume. Each request produces
// exactly one output transfer carrying the PC, accumulator, status and highest
// stored address after it. Both channels use valid and stall.
// After reset the data memory is swept to zero, one word per cycle, so input
// is stalled until the sweep is done and the first transfer can be taken.
// An input transfer is registered into the execute state and committed when the
// receiver does not stall; an indirect load reads the data memory twice in a row
// and commits from the indirect-read state. Throughput is one request per cycle
// while the receiver does not stall, for requests that do not write the data
// memory. Stores and preloads stall the next request, whose read is issued only
// after the write; indirect loads stall it too, as the memory has one read port.
// The architectural registers double as the output register; when the
// receiver stalls, the result holds and the next request waits in the input
// register until the output transfer completes.
module accumulator_cpu_core
  import acpu_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                req_type,
  input  logic [3:0]                opcode,
  input  logic signed [WORD_W-1:0]  operand,
  input  logic [LADDR_W-1:0]        load_address,
  input  logic signed [WORD_W-1:0]  load_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PC_W-1:0]           next_pc,
  output logic signed [WORD_W-1:0]  accumulator_out,
  output logic [2:0]                status_code,
  output logic [LADDR_W-1:0]        highest_written
);

  localparam int AW = $clog2(DATA_DEPTH);

  state_t                     state;
  state_t                     state_next;
  logic [AW-1:0]              clr_cnt;
  arch_t                      arch;
  logic [AW-1:0]              top;
  logic [AW+LADDR_W-1:0]      top_ext;

  logic [2:0]                 item_req;
  logic [3:0]                 item_op;
  logic signed [WORD_W-1:0]   item_operand;
  logic [LADDR_W-1:0]         item_laddr;
  logic signed [WORD_W-1:0]   item_lval;

  arch_t                      exec_nxt;
  logic [AW-1:0]              exec_top_next;
  exec_ctl_t                  ctl;
  logic [AW-1:0]              exec_waddr;
  logic [WORD_W-1:0]          exec_wdata;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [WORD_W-1:0]          ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [WORD_W-1:0]          ram_rdata;

  logic                       can_out;
  logic                       accept;
  logic                       commit;
  logic                       commit_ind;

  acpu_exec #(
    .DATA_DEPTH(DATA_DEPTH),
    .PROG_DEPTH(PROG_DEPTH)
  ) u_exec (
    .cur         (arch),
    .top         (top),
    .req_type    (item_req),
    .opcode      (item_op),
    .operand     (item_operand),
    .load_address(item_laddr),
    .load_value  (item_lval),
    .rdata       (ram_rdata),
    .nxt         (exec_nxt),
    .top_next    (exec_top_next),
    .ctl         (ctl),
    .waddr       (exec_waddr),
    .wdata       (exec_wdata)
  );

  acpu_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DATA_DEPTH)
  ) u_data_mem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign can_out = !out_valid || !out_stall;
  assign accept  = in_valid && !in_stall;

  always_comb begin
    in_stall   = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = exec_waddr;
    ram_wdata  = exec_wdata;
    ram_re     = 1'b0;
    ram_raddr  = operand[AW-1:0];
    commit     = 1'b0;
    commit_ind = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_EXEC: begin
        if (ctl.ind_read) begin
          ram_re    = 1'b1;
          ram_raddr = ram_rdata[AW-1:0];
        end else if (can_out) begin
          commit   = 1'b1;
          ram_we   = ctl.mem_we;
          in_stall = ctl.mem_we;
        end
      end
      ST_IND: begin
        if (can_out) begin
          commit_ind = 1'b1;
          in_stall   = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (in_valid && !in_stall) begin
      ram_re    = 1'b1;
      ram_raddr = operand[AW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(DATA_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ctl.ind_read) begin
          state_next = ST_IND;
        end else if (can_out) begin
          state_next = accept ? ST_EXEC : ST_IDLE;
        end
      end
      ST_IND: begin
        if (can_out) begin
          state_next = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      arch.acc    <= '0;
      arch.pc     <= '0;
      arch.status <= STAT_NORMAL;
      top         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (commit) begin
        arch <= exec_nxt;
        top  <= exec_top_next;
      end
      if (commit_ind) begin
        arch.acc <= ram_rdata;
        arch.pc  <= arch.pc + PC_W'(1);
      end
      if (commit || commit_ind) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_req     <= req_type;
      item_op      <= opcode;
      item_operand <= operand;
      item_laddr   <= load_address;
      item_lval    <= load_value;
    end
  end

  assign top_ext         = {{LADDR_W{1'b0}}, top};
  assign next_pc         = arch.pc;
  assign accumulator_out = arch.acc;
  assign status_code     = arch.status;
  assign highest_written = top_ext[LADDR_W-1:0];

  a_accept_enters_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("Accepted transfer did not enter execution.");

  a_ind_follows_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IND) |-> ($past(state) == ST_EXEC || $past(state) == ST_IND))
    else $error("Indirect read stage entered without an executing request.");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_CLEAR) |-> !accept)
    else $error("New request read the data memory during a write.");

  a_commit_has_room: assert property (@(posedge clk) disable iff (rst)
    (commit || commit_ind) |-> can_out)
    else $error("Result committed while the previous result was stalled.");

endmodule

/* test/accumulator_cpu_core_test.sv */
// Self-checking testbench for the accumulator CPU core, with its scoreboard class.
// Depends on acpu_pkg and accumulator_cpu_core; drives the valid/stall
// channels with random idling and holds.
module accumulator_cpu_core_test;
  import acpu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 120;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [3:0] OP_ILLEGAL_TOP = 4'd15;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct {
    logic [PC_W-1:0]    pc;
    logic [WORD_W-1:0]  acc;
    status_t            stat;
    logic [LADDR_W-1:0] top;
  } cpu_view_t;

  class cpu_scoreboard;
    logic [WORD_W-1:0]  acc;
    logic [PC_W-1:0]    pc;
    status_t            stat;
    logic [WORD_W-1:0]  mem [DATA_DEPTH_DEF];
    logic [LADDR_W-1:0] top;
    cpu_view_t          expected_q [$];
    int errors;
    int checked;
    int requests;
    int instructions;
    int taken_branches;
    int faults;

    function new();
      acc = '0;
      pc = '0;
      stat = STAT_NORMAL;
      top = '0;
      foreach (mem[i]) mem[i] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void run_instruction(logic [3:0] op, logic [WORD_W-1:0] n);
      logic [WORD_W-1:0] ptr;
      if (stat != STAT_NORMAL) return;
      instructions++;
      case (op)
        OP_LDI: acc = n;
        OP_LD, OP_ADD: begin
          if (n >= DATA_DEPTH_DEF) begin
            stat = STAT_MEMVIOL;
            return;
          end
          acc = (op == OP_LD) ? mem[n[6:0]] : acc + mem[n[6:0]];
        end
        OP_LDX, OP_STX: begin
          if (n >= DATA_DEPTH_DEF) begin
            stat = STAT_MEMVIOL;
            return;
          end
          ptr = mem[n[6:0]];
          if (ptr >= DATA_DEPTH_DEF) begin
            stat = STAT_MEMVIOL;
            return;
          end
          if (op == OP_LDX) begin
            acc = mem[ptr[6:0]];
          end else begin
            mem[ptr[6:0]] = acc;
            if (ptr[6:0] > top) top = ptr[6:0];
          end
        end
        OP_ST: begin
          if (n >= DATA_DEPTH_DEF) begin
            stat = STAT_MEMVIOL;
            return;
          end
          mem[n[6:0]] = acc;
          if (n[6:0] > top) top = n[6:0];
        end
        OP_NEG: acc = '0 - acc;
        OP_BRZ: begin
          if (acc == '0) begin
            if (n >= PROG_DEPTH_DEF) begin
              stat = STAT_MEMVIOL;
              return;
            end
            pc = n[6:0];
            taken_branches++;
            return;
          end
        end
        OP_HALT: stat = STAT_STOP;
        OP_RD: stat = STAT_READ;
        OP_WR: stat = STAT_WRITE;
        default: begin
          stat = STAT_ILLEGAL;
          return;
        end
      endcase
      pc = pc + 1'b1;
    endfunction

    function void note_request(logic [2:0] req, logic [3:0] op, logic [WORD_W-1:0] opnd,
                               logic [LADDR_W-1:0] laddr, logic [WORD_W-1:0] lval);
      cpu_view_t view;
      requests++;
      case (req)
        REQ_EXEC: run_instruction(op, opnd);
        REQ_PRELOAD: if (laddr < DATA_DEPTH_DEF) mem[laddr] = lval;
        REQ_SET_PC: pc = laddr;
        REQ_SET_ACC: acc = lval;
        REQ_RESUME: stat = STAT_NORMAL;
        default: ;
      endcase
      view.pc = pc;
      view.acc = acc;
      view.stat = stat;
      view.top = top;
      expected_q.push_back(view);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [PC_W-1:0] r_pc, logic [WORD_W-1:0] r_acc,
                               logic [2:0] r_stat, logic [LADDR_W-1:0] r_top);
      cpu_view_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, actual pc %0d acc %0h",
                 $time, r_pc, r_acc);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.stat != STAT_NORMAL) faults++;
      compare_field("next_pc", want.pc, r_pc);
      compare_field("accumulator_out", want.acc, r_acc);
      compare_field("status_code", want.stat, r_stat);
      compare_field("highest_written", want.top, r_top);
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [2:0]                req_type;
  logic [3:0]                opcode;
  logic signed [WORD_W-1:0]  operand;
  logic [LADDR_W-1:0]        load_address;
  logic signed [WORD_W-1:0]  load_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [PC_W-1:0]           next_pc;
  logic signed [WORD_W-1:0]  accumulator_out;
  logic [2:0]                status_code;
  logic [LADDR_W-1:0]        highest_written;

  cpu_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;
  int idle_cycles;

  accumulator_cpu_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .opcode(opcode),
    .operand(operand),
    .load_address(load_address),
    .load_value(load_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .next_pc(next_pc),
    .accumulator_out(accumulator_out),
    .status_code(status_code),
    .highest_written(highest_written)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_request(req_type, opcode, operand, load_address, load_value);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(next_pc, accumulator_out, status_code, highest_written);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_request(logic [2:0] req, logic [3:0] op, logic [WORD_W-1:0] opnd,
                              logic [LADDR_W-1:0] laddr, logic [WORD_W-1:0] lval);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    opcode <= op;
    operand <= opnd;
    load_address <= laddr;
    load_value <= lval;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic exec_op(logic [3:0] op, logic [WORD_W-1:0] opnd);
    send_request(REQ_EXEC, op, opnd, '0, '0);
  endtask

  task automatic send_random();
    int pick;
    logic [2:0] req;
    logic [3:0] op;
    logic [WORD_W-1:0] opnd;
    logic [WORD_W-1:0] lval;
    logic [LADDR_W-1:0] laddr;
    pick = $urandom_range(0, 99);
    op = 4'($urandom_range(0, 10));
    if ($urandom_range(0, 9) == 0) op = 4'($urandom_range(11, 15));
    opnd = $urandom_range(0, 127);
    case ($urandom_range(0, 9))
      0: opnd = $urandom;
      1: opnd = 128 + $urandom_range(0, 15);
      default: ;
    endcase
    if (op == OP_LDI && $urandom_range(0, 2) == 0) opnd = '0;
    laddr = LADDR_W'($urandom);
    lval = $urandom_range(0, 127);
    if ($urandom_range(0, 3) == 0) lval = $urandom;
    if (sb.stat != STAT_NORMAL && pick < 70) begin
      req = REQ_RESUME;
    end else if (pick < 55) begin
      req = REQ_EXEC;
    end else if (pick < 75) begin
      req = REQ_PRELOAD;
    end else if (pick < 82) begin
      req = REQ_SET_ACC;
      if ($urandom_range(0, 3) == 0) lval = '0;
    end else if (pick < 88) begin
      req = REQ_SET_PC;
    end else if (pick < 97) begin
      req = REQ_RESUME;
    end else begin
      req = 3'($urandom_range(5, 7));
    end
    send_request(req, op, opnd, laddr, lval);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= '0;
    opcode <= '0;
    operand <= '0;
    load_address <= '0;
    load_value <= '0;
    send_idle_pct = 23;
    recv_idle_pct = 69;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(REQ_PRELOAD, OP_LDI, '0, 7'd5, 32'd127);
    send_request(REQ_PRELOAD, OP_LDI, '0, 7'd127, 32'h8000_0000);
    send_request(REQ_PRELOAD, OP_LDI, '0, 7'd1, 32'd200);
    send_request(REQ_SET_ACC, OP_LDI, '0, '0, 32'h7FFF_FFFF);
    exec_op(OP_ADD, 32'd127);
    exec_op(OP_LD, 32'd127);
    exec_op(OP_NEG, '0);
    exec_op(OP_LDX, 32'd5);
    exec_op(OP_STX, 32'd5);
    exec_op(OP_LDX, 32'd1);
    exec_op(OP_LDI, 32'd1);
    send_request(REQ_RESUME, OP_LDI, '0, '0, '0);
    exec_op(OP_ST, 32'hFFFF_FFFF);
    send_request(REQ_SET_PC, OP_LDI, '0, 7'd127, '0);
    send_request(REQ_RESUME, OP_LDI, '0, '0, '0);
    exec_op(OP_LDI, '0);
    exec_op(OP_BRZ, 32'd128);
    send_request(REQ_RESUME, OP_LDI, '0, '0, '0);
    exec_op(OP_BRZ, 32'd100);
    exec_op(OP_LDI, 32'd3);
    exec_op(OP_BRZ, '0);
    exec_op(OP_ILLEGAL_TOP, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, OP_LDI, 32'hFFFF_FFFF, 7'h7F, 32'hFFFF_FFFF);
    send_request(REQ_RESUME, OP_LDI, '0, '0, '0);
    exec_op(OP_HALT, '0);
    send_request(REQ_RESUME, OP_LDI, '0, '0, '0);
    exec_op(OP_WR, '0);
    send_request(REQ_RESUME, OP_LDI, '0, '0, '0);
    repeat (255) send_random();
    wait_all_results();

    send_idle_pct = 69;
    recv_idle_pct = 23;
    repeat (280) send_random();
    wait_all_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) send_random();
    hold_request = 1'b1;
    repeat (250) send_random();
    wait_all_results();
    repeat (4) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    $display("Run covered %0d requests and %0d checked results: %0d instructions,",
             sb.requests, sb.checked, sb.instructions);
    $display("%0d taken branches and %0d results with a non-normal status.",
             sb.taken_branches, sb.faults);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
